// ===== sv/vwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vwd_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned NUM_CELLS   = 8;
  localparam int unsigned NUM_ROWS    = TABLE_DEPTH / NUM_CELLS;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned CELL_W      = $clog2(NUM_CELLS);
  localparam int unsigned ROW_W       = $clog2(NUM_ROWS);
  localparam int unsigned PIPE_DEPTH  = 4;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned UCNT_W      = 11;
  localparam logic [31:0] THR_RESET   = 32'd4295;

  typedef struct packed {
    logic               first_vertex;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } vwd_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  point_index;
    logic              is_new;
    logic              table_overflow;
    logic [UCNT_W-1:0] unique_count;
  } vwd_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vwd_point_t;

  typedef struct packed {
    logic              found;
    logic [CELL_W-1:0] lane;
  } vwd_chain_t;

endpackage

`default_nettype wire

// ===== sv/vwd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vwd_cell import vwd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CELL_W-1:0] cell_id_i,
  input  logic              wr_en_i,
  input  logic [ROW_W-1:0]  wr_row_i,
  input  vwd_point_t        wr_data_i,
  input  logic [ROW_W-1:0]  rd_row_i,
  input  logic              lane_vld_i,
  input  vwd_point_t        qry_i,
  input  logic [31:0]       thr_i,
  input  vwd_chain_t        chain_i,
  output vwd_chain_t        chain_o
);

  vwd_point_t mem_q [NUM_ROWS];
  vwd_point_t rd_q;
  logic       v1_q, v2_q, v3_q, hit_q;
  logic [15:0] ax_q, ay_q, az_q;
  logic        big2_q, big3_q;
  logic [31:0] sx_q, sy_q, sz_q;

  logic [32:0] dx, dy, dz;
  logic [32:0] adx, ady, adz;
  logic        big;
  logic [33:0] sum;
  logic [31:0] dsq;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_row_i];
  end

  // per-axis absolute difference, anything at or above 1.0 saturates
  always_comb begin
    dx  = {rd_q.x[31], rd_q.x} - {qry_i.x[31], qry_i.x};
    dy  = {rd_q.y[31], rd_q.y} - {qry_i.y[31], qry_i.y};
    dz  = {rd_q.z[31], rd_q.z} - {qry_i.z[31], qry_i.z};
    adx = dx[32] ? (33'd0 - dx) : dx;
    ady = dy[32] ? (33'd0 - dy) : dy;
    adz = dz[32] ? (33'd0 - dz) : dz;
    big = (|adx[32:16]) | (|ady[32:16]) | (|adz[32:16]);
  end

  always_comb begin
    sum = {2'b00, sx_q} + {2'b00, sy_q} + {2'b00, sz_q};
    dsq = (big3_q || (|sum[33:32])) ? 32'hFFFF_FFFF : sum[31:0];
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= adx[15:0];
    ay_q   <= ady[15:0];
    az_q   <= adz[15:0];
    big2_q <= big;
    sx_q   <= ax_q * ax_q;
    sy_q   <= ay_q * ay_q;
    sz_q   <= az_q * az_q;
    big3_q <= big2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v1_q  <= lane_vld_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      hit_q <= v3_q && (dsq < thr_i);
    end
  end

  // first hit in the row wins, lower lanes first
  assign chain_o.found = chain_i.found | hit_q;
  assign chain_o.lane  = chain_i.found ? chain_i.lane : cell_id_i;

endmodule

`default_nettype wire

// ===== sv/vertex_weld_dedup_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Vertex welder: each input word carries one Q16.16 vertex, and the result word gives the index
// of the first stored point whose squared distance is below the match threshold, or appends the
// vertex as a new point, or flags a table overflow when the table is full. The point table is
// split over a row of 8 identical cells, each with its own memory bank and distance unit, so
// one table row of 8 points is compared per cycle and a hit ripples down the cell chain to
// pick the lowest index. A search runs through row issue, memory read, 3 compare stages, the
// done state and the output register. The block returns to idle as the result is loaded and
// takes the next vertex from there, and a result still waiting in the output register holds
// the block in its done state. One vertex is in flight at a time, and a finished result waits
// in the output register while the next vertex is taken. first_vertex empties the table at
// once, with no clearing pass. The threshold port is always ready; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module vertex_weld_dedup_top import vwd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vwd_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vwd_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } vwd_state_e;

  vwd_state_e state_q, state_d;
  logic [ROW_W:0]        issue_row_q, issue_row_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [ROW_W-1:0]      row_q [PIPE_DEPTH];
  vwd_in_t               qry_q;
  vwd_out_t              res_q, res_d;
  vwd_out_t              out_q;
  logic                  out_valid_q;
  logic [31:0]           thr_q;

  vwd_point_t qry_pt;
  vwd_chain_t chain [NUM_CELLS+1];
  logic more_rows, hit_now, issue, done_miss, append, out_free;

  assign qry_pt.x = qry_q.pos_x;
  assign qry_pt.y = qry_q.pos_y;
  assign qry_pt.z = qry_q.pos_z;

  assign more_rows = {issue_row_q, {CELL_W{1'b0}}} < count_q;
  assign hit_now   = vld_q[PIPE_DEPTH-1] && chain[NUM_CELLS].found;
  assign issue     = (state_q == S_SEARCH) && more_rows && !hit_now;
  assign done_miss = (state_q == S_SEARCH) && !more_rows && (vld_q == '0);
  assign append    = done_miss && (count_q < CNT_W'(TABLE_DEPTH));
  assign out_free  = !out_valid_q || out_ready_i;

  assign chain[0] = '0;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    vwd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_id_i  (CELL_W'(c)),
      .wr_en_i    (append && (count_q[CELL_W-1:0] == CELL_W'(c))),
      .wr_row_i   (count_q[ADDR_W-1:CELL_W]),
      .wr_data_i  (qry_pt),
      .rd_row_i   (issue_row_q[ROW_W-1:0]),
      .lane_vld_i (issue && ({issue_row_q, CELL_W'(c)} < count_q)),
      .qry_i      (qry_pt),
      .thr_i      (thr_q),
      .chain_i    (chain[c]),
      .chain_o    (chain[c+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    issue_row_d = issue_row_q;
    count_d     = count_q;
    res_d       = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d     = S_SEARCH;
          issue_row_d = '0;
          if (in_data_i.first_vertex) begin
            count_d = '0;
          end
        end
      end
      S_SEARCH: begin
        if (issue) begin
          issue_row_d = issue_row_q + 1'b1;
        end
        if (hit_now) begin
          res_d.point_index    = IDX_W'({row_q[PIPE_DEPTH-1], chain[NUM_CELLS].lane});
          res_d.is_new         = 1'b0;
          res_d.table_overflow = 1'b0;
          state_d              = S_DONE;
        end else if (done_miss) begin
          if (append) begin
            res_d.point_index    = IDX_W'(count_q);
            res_d.is_new         = 1'b1;
            res_d.table_overflow = 1'b0;
            count_d              = count_q + 1'b1;
          end else begin
            res_d.point_index    = '0;
            res_d.is_new         = 1'b0;
            res_d.table_overflow = 1'b1;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_row_q <= '0;
      count_q     <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= THR_RESET;
    end else begin
      state_q     <= state_d;
      issue_row_q <= issue_row_d;
      count_q     <= count_d;
      if (hit_now) begin
        vld_q <= '0;
      end else begin
        vld_q <= {vld_q[PIPE_DEPTH-2:0], issue};
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q[0] <= issue_row_q[ROW_W-1:0];
    for (int s = 1; s < PIPE_DEPTH; s++) begin
      row_q[s] <= row_q[s-1];
    end
    res_q <= res_d;
    if (in_valid_i && in_ready_o) begin
      qry_q <= in_data_i;
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= {res_q.point_index, res_q.is_new, res_q.table_overflow, UCNT_W'(count_q)};
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// ===== sv/vwd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vwd_checker import vwd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  vwd_out_t out_data_i
);

  // result word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word dropped or changed while stalled");

  // overflow only with a full table and never as a new point
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.table_overflow |->
      !out_data_i.is_new && (out_data_i.unique_count == UCNT_W'(TABLE_DEPTH)))
    else $error("overflow result inconsistent");

  // a new point takes the last index
  a_new_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.is_new |->
      (out_data_i.unique_count - 1'b1) == UCNT_W'(out_data_i.point_index))
    else $error("new point index does not match count");

  // a matched point lies inside the table
  a_match_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.is_new && !out_data_i.table_overflow |->
      UCNT_W'(out_data_i.point_index) < out_data_i.unique_count)
    else $error("matched index beyond stored points");

endmodule

bind vertex_weld_dedup_top vwd_checker u_vwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

// ===== verif/vwd_checker.sv =====
`timescale 1ns / 1ps

module vwd_scoreboard import vwd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  vwd_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  vwd_out_t    out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          new_count_o,
  output int          weld_count_o,
  output int          overflow_count_o
);

  vwd_point_t  pt_table [TABLE_DEPTH];
  int unsigned n_points;
  logic [31:0] weld_thr;
  vwd_out_t    weld_q [$];
  vwd_out_t    want;
  int          n_fail;
  int          n_new;
  int          n_weld;
  int          n_ovf;

  // squared distance in 2^-32 units, saturating
  function automatic logic [31:0] sq_dist(input vwd_point_t p, input vwd_in_t v);
    longint d [3];
    longint sum;
    d[0] = longint'($signed(p.x)) - longint'($signed(v.pos_x));
    d[1] = longint'($signed(p.y)) - longint'($signed(v.pos_y));
    d[2] = longint'($signed(p.z)) - longint'($signed(v.pos_z));
    sum = 0;
    foreach (d[k]) begin
      if (d[k] < 0) d[k] = -d[k];
      if (d[k] >= 65536) return 32'hFFFF_FFFF;
      sum += d[k] * d[k];
    end
    if (sum > 64'h0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
    return 32'(sum);
  endfunction

  function automatic vwd_out_t weld_vertex(input vwd_in_t v);
    vwd_out_t r;
    bit       hit;
    r   = '0;
    hit = 1'b0;
    if (v.first_vertex) n_points = 0;
    for (int unsigned i = 0; i < n_points && !hit; i++) begin
      if (sq_dist(pt_table[i], v) < weld_thr) begin
        r.point_index = IDX_W'(i);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (n_points < TABLE_DEPTH) begin
        r.point_index = IDX_W'(n_points);
        pt_table[n_points].x = v.pos_x;
        pt_table[n_points].y = v.pos_y;
        pt_table[n_points].z = v.pos_z;
        n_points++;
        r.is_new = 1'b1;
      end else begin
        r.table_overflow = 1'b1;
      end
    end
    r.unique_count = UCNT_W'(n_points);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weld_thr = THR_RESET;
      n_points = 0;
      weld_q.delete();
      n_fail = 0;
      n_new  = 0;
      n_weld = 0;
      n_ovf  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) weld_thr = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        want = weld_vertex(in_data_i);
        weld_q = {weld_q, want};
        if (want.table_overflow) n_ovf++;
        else if (want.is_new) n_new++;
        else n_weld++;
      end
      if (out_valid_i && out_ready_i) begin
        if (weld_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result word with none expected: idx %0d new %0d ovf %0d cnt %0d",
                     $time, out_data_i.point_index, out_data_i.is_new,
                     out_data_i.table_overflow, out_data_i.unique_count);
        end else begin
          want = weld_q.pop_front();
          if (out_data_i.point_index !== want.point_index ||
              out_data_i.is_new !== want.is_new ||
              out_data_i.table_overflow !== want.table_overflow ||
              out_data_i.unique_count !== want.unique_count) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: mismatch: expected idx %0d new %0d ovf %0d cnt %0d",
                       $time, want.point_index, want.is_new, want.table_overflow,
                       want.unique_count);
              $display("%0t:           got idx %0d new %0d ovf %0d cnt %0d",
                       $time, out_data_i.point_index, out_data_i.is_new,
                       out_data_i.table_overflow, out_data_i.unique_count);
            end
          end
        end
      end
    end
    fail_count_o     <= n_fail;
    pending_o        <= weld_q.size();
    new_count_o      <= n_new;
    weld_count_o     <= n_weld;
    overflow_count_o <= n_ovf;
  end

endmodule

// ===== verif/tb_vertex_weld_dedup_top.sv =====
`timescale 1ns / 1ps

module tb_vertex_weld_dedup_top;
  import vwd_pkg::*;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PULSED} rx_mode_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  vwd_in_t     in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_ready;
  logic        out_valid;
  vwd_out_t    out_data;
  logic        cfg_ready;

  int fail_count;
  int pending;
  int new_count;
  int weld_count;
  int overflow_count;

  int          n_sent     = 0;
  int          burst_left = 0;
  int          near_span  = 67;
  vwd_in_t     mesh_pts [$];
  logic [31:0] fill_y [TABLE_DEPTH];
  logic [31:0] fill_z [TABLE_DEPTH];

  logic     long_hold_req = 1'b0;
  logic     hold_taken    = 1'b0;
  int       hold_left     = 0;
  rx_mode_e rx_mode       = RX_OPEN;
  int       rx_left       = 0;
  logic [7:0] rx_tick     = '0;

  vertex_weld_dedup_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  vwd_scoreboard weld_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .new_count_o      (new_count),
    .weld_count_o     (weld_count),
    .overflow_count_o (overflow_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: stall pattern of its own, plus one long hold-off on request
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (long_hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= 400;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(32, 256);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_tick[3:2] != 2'b00);
      endcase
    end
  end

  function automatic vwd_in_t vtx(input logic first, input logic [31:0] x, y, z);
    vwd_in_t v;
    v.first_vertex = first;
    v.pos_x        = x;
    v.pos_y        = y;
    v.pos_z        = z;
    return v;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 4 * near_span) - 2 * near_span;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    endcase
  endfunction

  function automatic logic [31:0] nudge(input logic [31:0] c);
    return c + $urandom_range(0, 2 * near_span) - near_span;
  endfunction

  // half fresh points, half exact or near repeats of this mesh's earlier vertices
  function automatic vwd_in_t make_vertex(input logic first);
    vwd_in_t     v;
    vwd_in_t     base;
    int unsigned pick;
    if (first) mesh_pts.delete();
    pick = $urandom_range(0, 9);
    if (mesh_pts.size() == 0 || pick >= 5) begin
      v = vtx(first, rand_coord(), rand_coord(), rand_coord());
    end else begin
      base = mesh_pts[$urandom_range(0, mesh_pts.size() - 1)];
      if (pick == 0) v = vtx(first, base.pos_x, base.pos_y, base.pos_z);
      else v = vtx(first, nudge(base.pos_x), nudge(base.pos_y), nudge(base.pos_z));
    end
    mesh_pts = {mesh_pts, v};
    return v;
  endfunction

  task automatic send_vertex(input vwd_in_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_threshold(input logic [31:0] thr);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    near_span = int'($sqrt(real'(thr))) + 2;
  endtask

  task automatic run_meshes(input int n_items);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(2, 30);
      if (len > left) len = left;
      for (int k = 0; k < len; k++)
        send_vertex(make_vertex(k == 0 ? ($urandom_range(0, 7) != 0)
                                       : ($urandom_range(0, 49) == 0)));
      left -= len;
    end
  endtask

  initial begin
    int j;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold, boundaries and saturation
    send_vertex(vtx(1, 0, 0, 0));
    send_vertex(vtx(0, 0, 0, 0));
    send_vertex(vtx(0, 65, 0, 0));
    send_vertex(vtx(0, 0, 66, 0));
    send_vertex(vtx(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_vertex(vtx(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_vertex(vtx(0, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001));
    send_vertex(vtx(0, 32'h0000_FFFF, 0, 0));
    send_vertex(vtx(0, 32'h0001_0000, 0, 0));
    send_vertex(vtx(1, 32'h0001_0000, 0, 0));
    send_vertex(vtx(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_vertex(vtx(0, 0, 0, 0));

    // zero threshold: even exact repeats are new
    set_threshold(0);
    send_vertex(vtx(1, 5, 5, 5));
    send_vertex(vtx(0, 5, 5, 5));

    // all-ones threshold: only saturated distances miss
    set_threshold(32'hFFFF_FFFF);
    send_vertex(vtx(1, 0, 0, 0));
    send_vertex(vtx(0, 32'h0000_FFFF, 32'h0000_FFFF, 0));
    send_vertex(vtx(0, 32'h0000_FFFF, 0, 0));
    send_vertex(vtx(0, 32'h7FFF_FFFF, 32'h8000_0000, 0));

    // distance equal to the threshold does not match
    set_threshold(4225);
    send_vertex(vtx(1, 0, 0, 0));
    send_vertex(vtx(0, 0, 0, 65));
    send_vertex(vtx(0, 0, 0, 64));

    // fill the table on a 2.0 spaced grid, then hits and overflows while full
    set_threshold(THR_RESET);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      fill_y[i] = $urandom;
      fill_z[i] = $urandom;
      send_vertex(vtx(i == 0, i * 32'h2_0000, fill_y[i], fill_z[i]));
    end
    j = TABLE_DEPTH - 1;
    send_vertex(vtx(0, j * 32'h2_0000, fill_y[j], fill_z[j]));
    for (int k = 0; k < 16; k++) begin
      j = $urandom_range(0, TABLE_DEPTH - 1);
      if (k % 2)
        send_vertex(vtx(0, j * 32'h2_0000 + 32'h1_0000, fill_y[j], fill_z[j]));
      else
        send_vertex(vtx(0, j * 32'h2_0000 + $urandom_range(0, 60) - 30, fill_y[j],
                        fill_z[j] + $urandom_range(0, 40) - 20));
    end

    set_threshold($urandom);
    long_hold_req <= 1'b1;
    run_meshes(100);
    set_threshold(THR_RESET);
    run_meshes(100);
    set_threshold(32'hFFFF_FFFF);
    run_meshes(60);
    set_threshold(0);
    run_meshes(40);
    set_threshold(32'h0010_0000);
    run_meshes(100);

    drain_results();
    repeat (NUM_ROWS + PIPE_DEPTH + 4) @(posedge clk);
    $display("covered %0d vertices: %0d new points, %0d welded, %0d rejected on a full table",
             n_sent, new_count, weld_count, overflow_count);
    $display("thresholds 0, 4225, reset, 2^20, all-ones and random; table filled to %0d",
             TABLE_DEPTH);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
